### src/bpc_pkg.sv
`timescale 1ns / 1ps
// bpc_pkg: widths, constants, register indexes and control types for the
// barometric pressure compensation pipeline; no dependencies

package bpc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int PRESS_W = 18;
  localparam int TOUT_W  = 15;

  // internal widths
  localparam int DT_W    = RAW_W + 1;          // signed temperature difference
  localparam int PROD_W  = DT_W + COEF_W + 1;  // dt times a coefficient
  localparam int DTSQ_W  = 2 * DT_W;           // dt squared
  localparam int TEMP_W  = 21;                 // first-order and final temperature
  localparam int T2_W    = 18;                 // dt^2 >> 31
  localparam int SQ_W    = 2 * TEMP_W;         // square of a temperature distance
  localparam int CORR_W  = 40;                 // off2, sens2, squares (non-negative)
  localparam int OFF_W   = 41;
  localparam int SENS_W  = 40;
  localparam int SPLIT_W = 20;                 // low half of sens in the split multiply
  localparam int MUL_W   = 64;                 // d1 times sens
  localparam int Q_W     = MUL_W - 21 + 1;     // (prod >> 21) - off

  // shift amounts
  localparam int TS_SH   = 23;
  localparam int OTC_SH  = 7;
  localparam int STC_SH  = 8;
  localparam int T2_SH   = 31;
  localparam int PROD_SH = 21;
  localparam int PRESS_SH = 15;

  // pipeline depth, input transfer to result register
  localparam int NSTG = 9;

  // temperature thresholds and output limits
  localparam logic signed [TEMP_W-1:0] TEMP_REF   = 21'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = -21'sd1500;
  localparam logic signed [TEMP_W-1:0] TOUT_MIN   = -21'sd8192;
  localparam logic signed [TEMP_W-1:0] TOUT_MAX   = 21'sd16383;
  localparam logic [PRESS_W-1:0]       PRESS_MAX  = 18'd262143;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TEMPCO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE  = 3'd5;

  // stage load enables for the split multiplier
  typedef struct packed {
    logic load_pp;
    logic load_sum;
  } bpc_mul_ctrl_t;

endpackage

### src/bpc_split_mul.sv
`timescale 1ns / 1ps
// bpc_split_mul: two-stage 24-bit unsigned by 40-bit signed multiplier built from two
// narrow partial products; depends on bpc_pkg

module bpc_split_mul import bpc_pkg::*; (
  input  logic                     clk,
  input  bpc_mul_ctrl_t            ctrl,
  input  logic [RAW_W-1:0]         a_in,
  input  logic signed [SENS_W-1:0] b_in,
  output logic signed [MUL_W-1:0]  prod
);

  localparam int LO_W = RAW_W + SPLIT_W;
  localparam int HI_W = RAW_W + 1 + SENS_W - SPLIT_W;

  logic [LO_W-1:0]          pp_lo_nxt, pp_lo_r;
  logic signed [HI_W-1:0]   pp_hi_nxt, pp_hi_r;
  logic signed [MUL_W-1:0]  prod_nxt, prod_r;

  // low half unsigned, high half carries the sign
  assign pp_lo_nxt = a_in * b_in[SPLIT_W-1:0];
  assign pp_hi_nxt = $signed({1'b0, a_in}) * $signed(b_in[SENS_W-1:SPLIT_W]);

  // true product fits 64 bits, so the sum wraps cleanly
  assign prod_nxt = $signed({pp_hi_r[MUL_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
                  + $signed({{(MUL_W-LO_W){1'b0}}, pp_lo_r});

  always_ff @(posedge clk) begin
    if (ctrl.load_pp) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (ctrl.load_sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### src/baro_pressure_compensate.sv
`timescale 1ns / 1ps
// baro_pressure_compensate: second-order temperature compensation of a
// barometric sensor; depends on bpc_pkg and bpc_split_mul
// throughput one item per cycle while out_stall is low, set by the nine-stage
// pipeline with one register stage per step
// each stage holds or advances on its own, so bubbles close up under output stall
// reset (synchronous, rst_n low) clears all stage valid bits and the six
// calibration coefficients; payload registers are not reset

module baro_pressure_compensate import bpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PRESS_W-1:0]       out_pressure_pa,
  output logic signed [TOUT_W-1:0] out_temp_centi,
  output logic                     out_saturated,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [COEF_W-1:0]        cfg_wdata
);

  // ---------------------------------------------------------------------------
  // calibration coefficients
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] coef_sens_base_r, coef_off_base_r, coef_sens_tempco_r;
  logic [COEF_W-1:0] coef_off_tempco_r, coef_ref_temp_r, coef_temp_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_sens_base_r   <= '0;
      coef_off_base_r    <= '0;
      coef_sens_tempco_r <= '0;
      coef_off_tempco_r  <= '0;
      coef_ref_temp_r    <= '0;
      coef_temp_slope_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SENS_BASE:   coef_sens_base_r   <= cfg_wdata;
        CFG_OFF_BASE:    coef_off_base_r    <= cfg_wdata;
        CFG_SENS_TEMPCO: coef_sens_tempco_r <= cfg_wdata;
        CFG_OFF_TEMPCO:  coef_off_tempco_r  <= cfg_wdata;
        CFG_REF_TEMP:    coef_ref_temp_r    <= cfg_wdata;
        CFG_TEMP_SLOPE:  coef_temp_slope_r  <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage valids and per-stage advance
  // a stage loads when it is empty or the stage after it moves on
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !valid_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = valid_r[NSTG-1];

  // ---------------------------------------------------------------------------
  // stage 1: signed temperature difference dT = D2 - ref * 256
  // ---------------------------------------------------------------------------
  logic signed [DT_W-1:0] dt_nxt, dt_s1_r;
  logic [RAW_W-1:0]       d1_s1_r;

  assign dt_nxt = $signed({1'b0, in_raw_temperature})
                - $signed({1'b0, coef_ref_temp_r, 8'd0});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt_s1_r <= dt_nxt;
      d1_s1_r <= in_raw_pressure;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the four products of dT, side by side
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] ts_nxt, otc_nxt, stc_nxt;
  logic signed [PROD_W-1:0] ts_s2_r, otc_s2_r, stc_s2_r;
  logic signed [DTSQ_W-1:0] dtsq_nxt, dtsq_s2_r;
  logic [RAW_W-1:0]         d1_s2_r;

  assign ts_nxt   = dt_s1_r * $signed({1'b0, coef_temp_slope_r});
  assign otc_nxt  = dt_s1_r * $signed({1'b0, coef_off_tempco_r});
  assign stc_nxt  = dt_s1_r * $signed({1'b0, coef_sens_tempco_r});
  assign dtsq_nxt = dt_s1_r * dt_s1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ts_s2_r   <= ts_nxt;
      otc_s2_r  <= otc_nxt;
      stc_s2_r  <= stc_nxt;
      dtsq_s2_r <= dtsq_nxt;
      d1_s2_r   <= d1_s1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: first-order TEMP, OFF, SENS and T2 (shifts are floors)
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] temp_nxt, temp_s3_r;
  logic signed [OFF_W-1:0]  off_nxt, off_s3_r;
  logic signed [SENS_W-1:0] sens_nxt, sens_s3_r;
  logic [T2_W-1:0]          t2_nxt, t2_s3_r;
  logic [RAW_W-1:0]         d1_s3_r;

  assign temp_nxt = TEMP_REF + $signed(ts_s2_r[PROD_W-1:TS_SH]);
  assign off_nxt  = $signed({{(OFF_W-COEF_W-16){1'b0}}, coef_off_base_r, 16'd0})
                  + $signed(otc_s2_r[PROD_W-1:OTC_SH]);
  assign sens_nxt = $signed({{(SENS_W-COEF_W-15){1'b0}}, coef_sens_base_r, 15'd0})
                  + $signed(stc_s2_r[PROD_W-1:STC_SH]);
  // dT^2 is never negative, so the floor is a plain bit slice
  assign t2_nxt   = dtsq_s2_r[T2_SH+T2_W-1:T2_SH];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      temp_s3_r <= temp_nxt;
      off_s3_r  <= off_nxt;
      sens_s3_r <= sens_nxt;
      t2_s3_r   <= t2_nxt;
      d1_s3_r   <= d1_s2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: cold flags and squared distances from 20 C and -15 C
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] dist_ref, dist_vcold;
  logic signed [SQ_W-1:0]   dsq_full, esq_full;
  logic [CORR_W-1:0]        dsq_s4_r, esq_s4_r;
  logic                     cold_nxt, vcold_nxt, cold_s4_r, vcold_s4_r;
  logic signed [TEMP_W-1:0] temp_s4_r;
  logic signed [OFF_W-1:0]  off_s4_r;
  logic signed [SENS_W-1:0] sens_s4_r;
  logic [T2_W-1:0]          t2_s4_r;
  logic [RAW_W-1:0]         d1_s4_r;

  assign dist_ref   = temp_s3_r - TEMP_REF;
  assign dist_vcold = temp_s3_r - TEMP_VCOLD;
  assign dsq_full   = dist_ref * dist_ref;
  assign esq_full   = dist_vcold * dist_vcold;
  // comparisons use TEMP before T2 comes off
  assign cold_nxt   = temp_s3_r < TEMP_REF;
  assign vcold_nxt  = temp_s3_r < TEMP_VCOLD;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dsq_s4_r   <= dsq_full[CORR_W-1:0];
      esq_s4_r   <= esq_full[CORR_W-1:0];
      cold_s4_r  <= cold_nxt;
      vcold_s4_r <= vcold_nxt;
      temp_s4_r  <= temp_s3_r;
      off_s4_r   <= off_s3_r;
      sens_s4_r  <= sens_s3_r;
      t2_s4_r    <= t2_s3_r;
      d1_s4_r    <= d1_s3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: OFF2, SENS2 and final temperature
  // all terms are non-negative, so floors are logical shifts
  // ---------------------------------------------------------------------------
  logic [CORR_W-1:0]        sq5, esq7, esq11;
  logic [CORR_W-1:0]        off2_nxt, sens2_nxt, off2_s5_r, sens2_s5_r;
  logic signed [TEMP_W-1:0] tempf_nxt, tempf_s5_r;
  logic signed [OFF_W-1:0]  off_s5_r;
  logic signed [SENS_W-1:0] sens_s5_r;
  logic [RAW_W-1:0]         d1_s5_r;

  assign sq5   = (dsq_s4_r << 2) + dsq_s4_r;
  assign esq7  = (esq_s4_r << 3) - esq_s4_r;
  assign esq11 = (esq_s4_r << 3) + (esq_s4_r << 1) + esq_s4_r;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    tempf_nxt = temp_s4_r;
    if (cold_s4_r) begin
      off2_nxt  = sq5 >> 1;
      sens2_nxt = sq5 >> 2;
      tempf_nxt = temp_s4_r - $signed({{(TEMP_W-T2_W){1'b0}}, t2_s4_r});
      // extra terms below -15 C
      if (vcold_s4_r) begin
        off2_nxt  = (sq5 >> 1) + esq7;
        sens2_nxt = (sq5 >> 2) + (esq11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      off2_s5_r  <= off2_nxt;
      sens2_s5_r <= sens2_nxt;
      tempf_s5_r <= tempf_nxt;
      off_s5_r   <= off_s4_r;
      sens_s5_r  <= sens_s4_r;
      d1_s5_r    <= d1_s4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: corrected OFF and SENS, temperature clamp
  // ---------------------------------------------------------------------------
  logic signed [OFF_W-1:0]  offf_nxt, offf_s6_r;
  logic signed [SENS_W:0]   sensf_full;
  logic signed [SENS_W-1:0] sensf_s6_r;
  logic signed [TEMP_W-1:0] tclamp;
  logic                     tsat_nxt, tsat_s6_r;
  logic signed [TOUT_W-1:0] tout_s6_r;
  logic [RAW_W-1:0]         d1_s6_r;

  assign offf_nxt   = off_s5_r - $signed({{(OFF_W-CORR_W){1'b0}}, off2_s5_r});
  assign sensf_full = $signed({sens_s5_r[SENS_W-1], sens_s5_r})
                    - $signed({{(SENS_W+1-CORR_W){1'b0}}, sens2_s5_r});

  always_comb begin
    tclamp   = tempf_s5_r;
    tsat_nxt = 1'b0;
    priority if (tempf_s5_r < TOUT_MIN) begin
      tclamp   = TOUT_MIN;
      tsat_nxt = 1'b1;
    end else if (tempf_s5_r > TOUT_MAX) begin
      tclamp   = TOUT_MAX;
      tsat_nxt = 1'b1;
    end else begin
      tclamp   = tempf_s5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      offf_s6_r  <= offf_nxt;
      sensf_s6_r <= sensf_full[SENS_W-1:0];
      tout_s6_r  <= tclamp[TOUT_W-1:0];
      tsat_s6_r  <= tsat_nxt;
      d1_s6_r    <= d1_s5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 7 and 8: D1 * SENS in the split multiplier
  // ---------------------------------------------------------------------------
  bpc_mul_ctrl_t           mul_ctrl;
  logic signed [MUL_W-1:0] prod_s8;
  logic signed [OFF_W-1:0] off_s7_r, off_s8_r;
  logic signed [TOUT_W-1:0] tout_s7_r, tout_s8_r;
  logic                    tsat_s7_r, tsat_s8_r;

  assign mul_ctrl.load_pp  = adv[6];
  assign mul_ctrl.load_sum = adv[7];

  bpc_split_mul u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .a_in (d1_s6_r),
    .b_in (sensf_s6_r),
    .prod (prod_s8)
  );

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      off_s7_r  <= offf_s6_r;
      tout_s7_r <= tout_s6_r;
      tsat_s7_r <= tsat_s6_r;
    end
    if (adv[7]) begin
      off_s8_r  <= off_s7_r;
      tout_s8_r <= tout_s7_r;
      tsat_s8_r <= tsat_s7_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: P = ((D1*SENS >> 21) - OFF) >> 15, clamp, result register
  // P is q[Q_W-1:PRESS_SH]; in range when its upper bits above 18 are zero
  // ---------------------------------------------------------------------------
  logic signed [Q_W-1:0]  q;
  logic [PRESS_W-1:0]     press_nxt, press_s9_r;
  logic                   psat;
  logic signed [TOUT_W-1:0] tout_s9_r;
  logic                   sat_s9_r;

  assign q = $signed(prod_s8[MUL_W-1:PROD_SH]) - off_s8_r;

  always_comb begin
    press_nxt = q[PRESS_SH+PRESS_W-1:PRESS_SH];
    psat      = 1'b0;
    priority if (q[Q_W-1]) begin
      press_nxt = '0;
      psat      = 1'b1;
    end else if (|q[Q_W-2:PRESS_SH+PRESS_W]) begin
      press_nxt = PRESS_MAX;
      psat      = 1'b1;
    end else begin
      psat      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      press_s9_r <= press_nxt;
      tout_s9_r  <= tout_s8_r;
      sat_s9_r   <= psat || tsat_s8_r;
    end
  end

  assign out_pressure_pa = press_s9_r;
  assign out_temp_centi  = tout_s9_r;
  assign out_saturated   = sat_s9_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a clamp flag always comes with some output sitting on a range end
  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_pressure_pa == '0) || (out_pressure_pa == PRESS_MAX) ||
      (out_temp_centi == TOUT_MIN[TOUT_W-1:0]) ||
      (out_temp_centi == TOUT_MAX[TOUT_W-1:0]))
    else $error("saturated flag without a clamped output");

  // input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while the pipeline has a free stage");

  // very cold implies cold
  a_cold_nest: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] |-> (cold_s4_r || !vcold_s4_r))
    else $error("very-cold flag set without cold flag");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("stage valid left set after reset");

endmodule

### tb/baro_pressure_compensate_tb.sv
`timescale 1ns / 1ps
// baro_pressure_compensate_tb: self-checking bench for the barometric
// compensation pipeline, with its own 64-bit integer model of the math
// depends on bpc_pkg and baro_pressure_compensate

module baro_pressure_compensate_tb;
  import bpc_pkg::*;

  // spare register indexes, writes there must leave every coefficient alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_TEMP_SLOPE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  // cycles without any transfer, while work is pending, before giving up
  localparam int QUIET_LIMIT = 2000;
  // accepted readings between forced drains of the pipeline
  localparam int DRAIN_EVERY = 64;
  localparam int RAND_PHASES = 8;
  localparam int RAND_PER_PHASE = 68;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } raw_pair_t;

  typedef struct packed {
    logic [PRESS_W-1:0]       pressure_pa;
    logic signed [TOUT_W-1:0] temp_centi;
    logic                     saturated;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [RAW_W-1:0]         in_raw_pressure = '0;
  logic [RAW_W-1:0]         in_raw_temperature = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PRESS_W-1:0]       out_pressure_pa;
  logic signed [TOUT_W-1:0] out_temp_centi;
  logic                     out_saturated;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [COEF_W-1:0]        cfg_wdata = '0;

  // calibration as the bench believes the block holds it (reset value 0)
  logic [COEF_W-1:0] cal_sens_base = '0;
  logic [COEF_W-1:0] cal_off_base = '0;
  logic [COEF_W-1:0] cal_sens_tempco = '0;
  logic [COEF_W-1:0] cal_off_tempco = '0;
  logic [COEF_W-1:0] cal_ref_temp = '0;
  logic [COEF_W-1:0] cal_temp_slope = '0;

  raw_pair_t readings_q[$];     // readings waiting to be driven
  reading_t  compensated_q[$];  // predicted results, oldest first
  raw_pair_t cur_pair;
  reading_t  head_result;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  err_cnt = 0;
  int  n_accepted = 0;
  int  quiet_cycles = 0;
  logic drain_hold = 1'b0;

  baro_pressure_compensate i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pressure_pa    (out_pressure_pa),
    .out_temp_centi     (out_temp_centi),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // second-order compensation in signed 64-bit integers; every >>> on a
  // longint is a floor, which is what the divisions by powers of two need
  function automatic reading_t compensate(raw_pair_t r);
    longint d1, d2, dt, t, off, sens, t2, off2, sens2, tdist, sq, p;
    longint sb, ob, stc, otc, rt, sl, p_max;
    reading_t res;
    d1 = r.raw_pressure;
    d2 = r.raw_temperature;
    sb = cal_sens_base;
    ob = cal_off_base;
    stc = cal_sens_tempco;
    otc = cal_off_tempco;
    rt = cal_ref_temp;
    sl = cal_temp_slope;
    p_max = PRESS_MAX;
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    res.saturated = 1'b0;

    // first order: dt is signed, so a cold reading goes negative
    dt = d2 - rt * 256;
    t = TEMP_REF + ((dt * sl) >>> TS_SH);
    off = ob * 65536 + ((otc * dt) >>> OTC_SH);
    sens = sb * 32768 + ((stc * dt) >>> STC_SH);

    // cold and very cold terms, decided on the first-order temperature
    if (t < TEMP_REF) begin
      tdist = t - TEMP_REF;
      sq = 5 * tdist * tdist;
      t2 = (dt * dt) >>> T2_SH;
      off2 = sq >>> 1;
      sens2 = sq >>> 2;
      if (t < TEMP_VCOLD) begin
        tdist = t - TEMP_VCOLD;
        sq = tdist * tdist;
        off2 = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
    end
    t = t - t2;
    off = off - off2;
    sens = sens - sens2;

    p = (((d1 * sens) >>> PROD_SH) - off) >>> PRESS_SH;

    // clamp both outputs to their ranges
    if (p < 0) begin
      p = 0;
      res.saturated = 1'b1;
    end
    if (p > p_max) begin
      p = p_max;
      res.saturated = 1'b1;
    end
    if (t < TOUT_MIN) begin
      t = TOUT_MIN;
      res.saturated = 1'b1;
    end
    if (t > TOUT_MAX) begin
      t = TOUT_MAX;
      res.saturated = 1'b1;
    end
    res.pressure_pa = p[PRESS_W-1:0];
    res.temp_centi = t[TOUT_W-1:0];
    return res;
  endfunction

  // one register write per clock; the caller lowers cfg_we afterwards
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SENS_BASE:   cal_sens_base = val;
      CFG_OFF_BASE:    cal_off_base = val;
      CFG_SENS_TEMPCO: cal_sens_tempco = val;
      CFG_OFF_TEMPCO:  cal_off_tempco = val;
      CFG_REF_TEMP:    cal_ref_temp = val;
      CFG_TEMP_SLOPE:  cal_temp_slope = val;
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [COEF_W-1:0] sb, ob, stc, otc, rt, sl);
    write_coef(CFG_SENS_BASE, sb);
    write_coef(CFG_OFF_BASE, ob);
    write_coef(CFG_SENS_TEMPCO, stc);
    write_coef(CFG_OFF_TEMPCO, otc);
    write_coef(CFG_REF_TEMP, rt);
    write_coef(CFG_TEMP_SLOPE, sl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void queue_reading(input logic [RAW_W-1:0] d1, d2);
    raw_pair_t r;
    r.raw_pressure = d1;
    r.raw_temperature = d2;
    readings_q.push_back(r);
  endfunction

  // checked away from the rising edge so every driver update has landed
  task automatic wait_idle();
    do @(negedge clk);
    while (readings_q.size() != 0 || in_valid || compensated_q.size() != 0);
  endtask

  // driver: a new reading is offered only once the current one has transferred,
  // so valid stays high and the payload holds while the block stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drain_hold <= 1'b0;
      n_accepted <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        compensated_q.push_back(compensate(raw_pair_t'({in_raw_pressure, in_raw_temperature})));
        n_accepted <= n_accepted + 1;
        // every so often, hold off until the pipeline has emptied
        if (n_accepted % DRAIN_EVERY == DRAIN_EVERY - 1) drain_hold <= 1'b1;
      end else if (drain_hold && !in_valid && compensated_q.size() == 0) begin
        drain_hold <= 1'b0;
      end
      if (!in_valid || !in_stall) begin
        if (readings_q.size() != 0 && !drain_hold && $urandom_range(99) >= send_idle_pct) begin
          cur_pair = readings_q.pop_front();
          in_valid <= 1'b1;
          in_raw_pressure <= cur_pair.raw_pressure;
          in_raw_temperature <= cur_pair.raw_temperature;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (compensated_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          $display("%0t: result with none expected, expected nothing, actual p=%0d t=%0d sat=%0b",
                   $time, out_pressure_pa, out_temp_centi, out_saturated);
        end else begin
          head_result = compensated_q.pop_front();
          if (out_pressure_pa !== head_result.pressure_pa) begin
            err_cnt = err_cnt + 1;
            $display("%0t: pressure_pa mismatch, expected %0d, actual %0d",
                     $time, head_result.pressure_pa, out_pressure_pa);
          end
          if (out_temp_centi !== head_result.temp_centi) begin
            err_cnt = err_cnt + 1;
            $display("%0t: temp_centi mismatch, expected %0d, actual %0d",
                     $time, head_result.temp_centi, out_temp_centi);
          end
          if (out_saturated !== head_result.saturated) begin
            err_cnt = err_cnt + 1;
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, head_result.saturated, out_saturated);
          end
        end
      end
    end
  end

  // watchdog: only counts while something is still owed
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (readings_q.size() == 0 && compensated_q.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [RAW_W-1:0] p_raw, t_raw;
    logic [COEF_W-1:0] val;
    longint near;
    idle_mode_t mode;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // calibration still at reset: everything collapses to 20.00 C and 0 Pa
    queue_reading('0, '0);
    queue_reading('1, '1);
    queue_reading(24'hAAAAAA, 24'h555555);
    queue_reading(24'h555555, 24'hAAAAAA);
    wait_idle();

    // typical sensor calibration, then writes to the spare indexes which
    // must not land anywhere
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    write_coef(CFG_SPARE_LO, 16'hFFFF);
    write_coef(CFG_SPARE_HI, 16'h0000);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_reading(24'd9085466, 24'd8569150);  // warm, around room temperature
    queue_reading(24'd9085466, 24'd8566784);  // exactly 20.00 C, no correction
    queue_reading(24'd9085466, 24'd8566783);  // one step into the cold branch
    queue_reading(24'd9085466, 24'd7529764);  // exactly -15.00 C, cold only
    queue_reading(24'd9085466, 24'd7529763);  // just into the very cold branch
    queue_reading('0, '0);                    // zero pressure reading, temp clamps low
    queue_reading('1, '1);                    // pressure and temp clamp high
    queue_reading('0, '1);
    queue_reading('1, '0);
    queue_reading(24'd9085466, '0);
    queue_reading(24'd9085466, '1);
    wait_idle();

    // every coefficient at its top value
    load_cal('1, '1, '1, '1, '1, '1);
    queue_reading('0, '0);
    queue_reading('1, '1);
    queue_reading('1, '0);
    queue_reading('0, '1);
    queue_reading(24'h800000, 24'hFF0000);
    wait_idle();

    // random part: idling style rotates, calibration changes each phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = idle_mode_t'(ph % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct = 71;
          stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase

      if (ph == 0) begin
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      end else begin
        for (int r = CFG_SENS_BASE; r <= CFG_TEMP_SLOPE; r++) begin
          case ($urandom_range(7))
            0: val = '0;
            1: val = '1;
            default: val = COEF_W'($urandom);
          endcase
          write_coef(CFG_IDX_W'(r), val);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
      end

      repeat (RAND_PER_PHASE) begin
        case ($urandom_range(7))
          0: p_raw = '0;
          1: p_raw = '1;
          default: p_raw = RAW_W'($urandom);
        endcase
        // half of the temperatures land near the reference so that the warm, cold
        // and very cold branches all get exercised
        case ($urandom_range(7))
          0: t_raw = '0;
          1: t_raw = '1;
          2, 3: t_raw = RAW_W'($urandom);
          default: begin
            near = longint'(cal_ref_temp) * 256 + $urandom_range(4194304) - 2097152;
            if (near < 0) near = 0;
            if (near > (1 << RAW_W) - 1) near = (1 << RAW_W) - 1;
            t_raw = near[RAW_W-1:0];
          end
        endcase
        queue_reading(p_raw, t_raw);
      end
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (2 * NSTG + 8) @(posedge clk);
    if (compensated_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, compensated_q.size());
    if (err_cnt == 0 && compensated_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
src/bpc_pkg.sv
src/bpc_split_mul.sv
src/baro_pressure_compensate.sv
tb/baro_pressure_compensate_tb.sv
